@@ rtl/uvs_pkg.sv @@
// Package for the UV-sphere vertex generator: payload structs, CORDIC table,
// and constants shared by the front end, back end and top level.
// No dependencies.
package uvs_pkg;

  localparam int CntW      = 11;
  localparam int StackW    = 11;
  localparam int SliceW    = 10;
  localparam int CoordW    = 16;
  localparam int VidxW     = 20;
  localparam int CfgIdxW   = 1;
  localparam int PhaseW    = 32;
  localparam int CordicN   = 30;
  localparam int CordicW   = 34;
  localparam int CordicFrac = 30;
  localparam int DivSteps  = 33;
  localparam logic [CordicW-1:0] CordicGainStart = 34'sd652032874;

  localparam logic [CfgIdxW-1:0] RegSliceCount = 1'b0;
  localparam logic [CfgIdxW-1:0] RegStackCount = 1'b1;

  localparam logic [CntW-1:0] SliceReset = 11'd10;
  localparam logic [CntW-1:0] StackReset = 11'd10;

  typedef struct packed {
    logic [StackW-1:0] stack_index;
    logic [SliceW-1:0] slice_index;
  } req_t;

  typedef struct packed {
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
    logic signed [CoordW-1:0] coord_z;
    logic [VidxW-1:0]         vertex_index;
    logic                     range_error;
  } res_t;

  // Item class decided by the front end.
  typedef enum logic [1:0] {
    KindRegular = 2'd0,
    KindNorth   = 2'd1,
    KindSouth   = 2'd2,
    KindError   = 2'd3
  } kind_e;

  // Work item handed from front to back through the queue.
  typedef struct packed {
    kind_e            kind;
    logic [SliceW:0]  stack;
    logic [SliceW:0]  slice;
    logic [CntW-1:0]  stacks;
    logic [CntW-1:0]  slices;
    logic [VidxW-1:0] vidx;
  } work_t;

  // Arctangents in 2^-32 turn units.
  function automatic logic [PhaseW-1:0] atan_turn(input logic [4:0] i);
    logic [PhaseW-1:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933405;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10680862;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/uvs_front.sv @@
// Front end: clamps the counts, checks ranges, classifies the request and
// computes the buffer index. Depends on uvs_pkg.
module uvs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  uvs_pkg::req_t     req_i,
  input  logic [10:0]       slice_count_i,
  input  logic [10:0]       stack_count_i,
  output logic              wk_valid_o,
  output uvs_pkg::work_t    wk_o
);
  import uvs_pkg::*;

  logic [CntW-1:0] slices, stacks;
  logic [SliceW:0] stk, slc;
  logic            v1_q;
  work_t           w1_q;
  logic [2*CntW-1:0] prod;
  logic            v2_q;
  work_t           w2_q;
  work_t           w2_d;

  // Saturate the counts and extend the indices; the class is set in the register below.
  always_comb begin
    slices = (slice_count_i < 11'd3) ? 11'd3 :
             (slice_count_i > 11'd1024) ? 11'd1024 : slice_count_i;
    stacks = (stack_count_i < 11'd2) ? 11'd2 :
             (stack_count_i > 11'd1024) ? 11'd1024 : stack_count_i;
    stk = req_i.stack_index;
    slc = {1'b0, req_i.slice_index};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    w1_q.stack  <= stk;
    w1_q.slice  <= slc;
    w1_q.stacks <= stacks;
    w1_q.slices <= slices;
    w1_q.vidx   <= '0;
    if (stk > stacks || slc >= slices) w1_q.kind <= KindError;
    else if (stk == '0)                w1_q.kind <= KindNorth;
    else if (stk == stacks)            w1_q.kind <= KindSouth;
    else                               w1_q.kind <= KindRegular;
  end

  // Buffer index: one multiplication and the add, both in the stage before w2_q.
  always_comb prod = (w1_q.stack - 11'd1) * w1_q.slices;

  always_comb begin
    w2_d = w1_q;
    unique case (w1_q.kind) inside
      KindNorth, KindError: w2_d.vidx = '0;
      default: w2_d.vidx = VidxW'(prod + 22'd1 +
                (w1_q.kind == KindSouth ? 22'd0 : 22'(w1_q.slice)));
    endcase
  end

  always_ff @(posedge clk_i) begin
    w2_q <= w2_d;
  end

  assign wk_valid_o = v2_q;
  assign wk_o       = w2_q;
endmodule

@@ rtl/uvs_queue.sv @@
// Short queue between front and back ends; the back end never stalls, so
// it is a register stage with a valid bit. Depends on uvs_pkg.
module uvs_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  uvs_pkg::work_t in_i,
  output logic           out_valid_o,
  output uvs_pkg::work_t out_o
);
  import uvs_pkg::*;

  logic  v_q;
  work_t d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= 1'b0;
    else         v_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) d_q <= in_i;
  end

  assign out_valid_o = v_q;
  assign out_o       = d_q;
endmodule

@@ rtl/uvs_back.sv @@
// Back end: pipelined phase dividers, two pipelined CORDICs, products,
// rounding and the result register. Depends on uvs_pkg.
module uvs_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wk_valid_i,
  input  uvs_pkg::work_t wk_i,
  output logic           res_valid_o,
  output uvs_pkg::res_t  res_o
);
  import uvs_pkg::*;

  localparam int DivW = 44;
  localparam int Lat  = DivSteps + 1 + CordicN + 1;

  // Divider pipeline: restoring division, one quotient bit per stage.
  logic [DivW-1:0]   pn_q [DivSteps+1];
  logic [DivW-1:0]   an_q [DivSteps+1];
  logic [CntW:0]     pd_q [DivSteps+1];
  logic [CntW-1:0]   ad_q [DivSteps+1];
  logic [DivW-1:0]   pr_q [DivSteps+1];
  logic [DivW-1:0]   ar_q [DivSteps+1];
  logic [PhaseW-1:0] pq_q [DivSteps+1];
  logic [PhaseW-1:0] aq_q [DivSteps+1];
  logic [DivW-1:0]   pnum, anum;

  // Side-band delay line carrying class and index.
  logic  v_q [Lat+1];
  work_t w_q [Lat+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= Lat; i++) v_q[i] <= 1'b0;
    end else begin
      v_q[0] <= wk_valid_i;
      for (int i = 1; i <= Lat; i++) v_q[i] <= v_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    w_q[0] <= wk_i;
    for (int i = 1; i <= Lat; i++) w_q[i] <= w_q[i-1];
  end

  // Numerators of the two phases.
  always_comb begin
    pnum = DivW'({wk_i.stack, 32'd0}) + DivW'(wk_i.stacks);
    anum = DivW'({wk_i.slice, 32'd0}) + DivW'(wk_i.slices[CntW-1:1]);
  end

  // Numerators and divisors loaded. For in-range items the bits above the low 33
  // are below the divisor, so they seed the partial remainder directly.
  always_ff @(posedge clk_i) begin
    pn_q[0] <= pnum;
    pd_q[0] <= {wk_i.stacks, 1'b0};
    an_q[0] <= anum;
    ad_q[0] <= wk_i.slices;
    pr_q[0] <= pnum >> DivSteps;
    ar_q[0] <= anum >> DivSteps;
    pq_q[0] <= '0;
    aq_q[0] <= '0;
  end

  // Each stage brings in one of the low 33 numerator bits, top first
  // (quotients fit in 33 bits, only the low 32 kept).
  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    logic [DivW-1:0] pt, at;
    always_comb begin
      pt = {pr_q[g][DivW-2:0], pn_q[g][DivSteps-1-g]};
      at = {ar_q[g][DivW-2:0], an_q[g][DivSteps-1-g]};
    end
    always_ff @(posedge clk_i) begin
      pn_q[g+1] <= pn_q[g];
      an_q[g+1] <= an_q[g];
      pd_q[g+1] <= pd_q[g];
      ad_q[g+1] <= ad_q[g];
      if (pt >= DivW'(pd_q[g])) begin
        pr_q[g+1] <= pt - DivW'(pd_q[g]);
        pq_q[g+1] <= {pq_q[g][PhaseW-2:0], 1'b1};
      end else begin
        pr_q[g+1] <= pt;
        pq_q[g+1] <= {pq_q[g][PhaseW-2:0], 1'b0};
      end
      if (at >= DivW'(ad_q[g])) begin
        ar_q[g+1] <= at - DivW'(ad_q[g]);
        aq_q[g+1] <= {aq_q[g][PhaseW-2:0], 1'b1};
      end else begin
        ar_q[g+1] <= at;
        aq_q[g+1] <= {aq_q[g][PhaseW-2:0], 1'b0};
      end
    end
  end

  // Quadrant fold and CORDIC pipelines.
  logic signed [CordicW-1:0] px_q [CordicN+1], py_q [CordicN+1], pz_q [CordicN+1];
  logic signed [CordicW-1:0] ax_q [CordicN+1], ay_q [CordicN+1], az_q [CordicN+1];
  logic pf_q [CordicN+1], af_q [CordicN+1];

  always_ff @(posedge clk_i) begin
    logic [PhaseW-1:0] pp, ap, pt2, at2;
    pp = pq_q[DivSteps];
    ap = aq_q[DivSteps];
    pt2 = pp + 32'h4000_0000;
    at2 = ap + 32'h4000_0000;
    pf_q[0] <= pt2[31];
    af_q[0] <= at2[31];
    pz_q[0] <= CordicW'($signed(pt2[31] ? pp - 32'h8000_0000 : pp));
    az_q[0] <= CordicW'($signed(at2[31] ? ap - 32'h8000_0000 : ap));
    px_q[0] <= CordicGainStart;
    ax_q[0] <= CordicGainStart;
    py_q[0] <= '0;
    ay_q[0] <= '0;
  end

  for (genvar g = 0; g < CordicN; g++) begin : g_cor
    localparam logic [4:0] Idx = 5'(g);
    always_ff @(posedge clk_i) begin
      pf_q[g+1] <= pf_q[g];
      af_q[g+1] <= af_q[g];
      if (!pz_q[g][CordicW-1]) begin
        px_q[g+1] <= px_q[g] - (py_q[g] >>> g);
        py_q[g+1] <= py_q[g] + (px_q[g] >>> g);
        pz_q[g+1] <= pz_q[g] - $signed(CordicW'(atan_turn(Idx)));
      end else begin
        px_q[g+1] <= px_q[g] + (py_q[g] >>> g);
        py_q[g+1] <= py_q[g] - (px_q[g] >>> g);
        pz_q[g+1] <= pz_q[g] + $signed(CordicW'(atan_turn(Idx)));
      end
      if (!az_q[g][CordicW-1]) begin
        ax_q[g+1] <= ax_q[g] - (ay_q[g] >>> g);
        ay_q[g+1] <= ay_q[g] + (ax_q[g] >>> g);
        az_q[g+1] <= az_q[g] - $signed(CordicW'(atan_turn(Idx)));
      end else begin
        ax_q[g+1] <= ax_q[g] + (ay_q[g] >>> g);
        ay_q[g+1] <= ay_q[g] - (ax_q[g] >>> g);
        az_q[g+1] <= az_q[g] + $signed(CordicW'(atan_turn(Idx)));
      end
    end
  end

  // Sign restore, then the two products (32x32, values stay below 2^31).
  logic signed [CordicW-1:0] cp, sp, ca, sa;
  always_comb begin
    cp = pf_q[CordicN] ? -px_q[CordicN] : px_q[CordicN];
    sp = pf_q[CordicN] ? -py_q[CordicN] : py_q[CordicN];
    ca = af_q[CordicN] ? -ax_q[CordicN] : ax_q[CordicN];
    sa = af_q[CordicN] ? -ay_q[CordicN] : ay_q[CordicN];
  end

  logic signed [2*CordicW-1:0] mx_q, my_q;
  logic signed [CordicW-1:0]   mz_q;
  always_ff @(posedge clk_i) begin
    mx_q <= ca * sp;
    my_q <= sa * sp;
    mz_q <= cp;
  end

  // Round half up and saturate to +/- one.
  function automatic logic [CoordW-1:0] rnd(input logic signed [2*CordicW-1:0] v,
                                            input int s);
    logic signed [2*CordicW-1:0] r;
    r = (v + (68'sd1 <<< (s - 1))) >>> s;
    if (r > 68'sd16384)       r = 68'sd16384;
    else if (r < -68'sd16384) r = -68'sd16384;
    return r[CoordW-1:0];
  endfunction

  res_t r_q;
  logic rv_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rv_q <= 1'b0;
    else         rv_q <= v_q[Lat];
  end

  always_ff @(posedge clk_i) begin
    r_q.vertex_index <= w_q[Lat].vidx;
    r_q.range_error  <= (w_q[Lat].kind == KindError);
    case (w_q[Lat].kind)
      KindError: begin
        r_q.coord_x <= '0; r_q.coord_y <= '0; r_q.coord_z <= '0;
      end
      KindNorth: begin
        r_q.coord_x <= '0; r_q.coord_y <= '0; r_q.coord_z <= 16'sd16384;
      end
      KindSouth: begin
        r_q.coord_x <= '0; r_q.coord_y <= '0; r_q.coord_z <= -16'sd16384;
      end
      default: begin
        r_q.coord_x <= rnd(mx_q, 2 * CordicFrac - 14);
        r_q.coord_y <= rnd(my_q, 2 * CordicFrac - 14);
        r_q.coord_z <= rnd((2*CordicW)'(mz_q), CordicFrac - 14);
      end
    endcase
  end

  assign res_valid_o = rv_q;
  assign res_o       = r_q;
endmodule

@@ rtl/uv_sphere_vertex_generator.sv @@
// Top level of the UV-sphere vertex generator: configuration registers,
// front end, queue and back end. Depends on uvs_pkg and the uvs_* modules.
//
//  channel   signals                         transfer when
//  request   start, busy, req_i               start && !busy
//  result    done_o, res_o                    done_o (one cycle)
//  config    cfg_we_i, cfg_idx_i, cfg_data_i  cfg_we_i
//
// One request per cycle; each result passes through the front end, the queue and
// the back end, and is taken while done_o is high.
// The latency comes mostly from the 33-stage phase dividers and the 30-stage CORDICs.
// busy is always low; the receiver cannot stall, so nothing holds back.
// Reset clears the valid bits and loads both counts with 10.
module uv_sphere_vertex_generator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  uvs_pkg::req_t              req_i,
  output logic                       done_o,
  output uvs_pkg::res_t              res_o,
  input  logic                       cfg_we_i,
  input  logic [0:0]                 cfg_idx_i,
  input  logic [10:0]                cfg_data_i
);
  import uvs_pkg::*;

  logic [CntW-1:0] slice_count_q, stack_count_q;
  logic  wk_valid, q_valid;
  work_t wk, qd;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_count_q <= SliceReset;
      stack_count_q <= StackReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegSliceCount: slice_count_q <= cfg_data_i;
        RegStackCount: stack_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  uvs_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i   (start && !busy),
    .req_i,
    .slice_count_i(slice_count_q),
    .stack_count_i(stack_count_q),
    .wk_valid_o   (wk_valid),
    .wk_o         (wk)
  );

  uvs_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i (wk_valid),
    .in_i       (wk),
    .out_valid_o(q_valid),
    .out_o      (qd)
  );

  uvs_back u_back (
    .clk_i, .rst_ni,
    .wk_valid_i (q_valid),
    .wk_i       (qd),
    .res_valid_o(done_o),
    .res_o
  );
endmodule

@@ rtl/uvs_checker.sv @@
// Port-level checker for the UV-sphere vertex generator, bound to the top.
// Depends on uvs_pkg.
module uvs_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          done_o,
  input uvs_pkg::res_t res_o
);
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.range_error |-> res_o.vertex_index == '0 && res_o.coord_z == '0)
    else $error("error result has nonzero fields");
  a_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> res_o.coord_x <= 16'sd16384 && res_o.coord_x >= -16'sd16384)
    else $error("coord_x out of range");
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");
  a_z_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> res_o.coord_z <= 16'sd16384 && res_o.coord_z >= -16'sd16384)
    else $error("coord_z out of range");
endmodule

bind uv_sphere_vertex_generator uvs_checker u_chk (
  .clk_i, .rst_ni, .start, .busy, .done_o, .res_o
);
